// ===== src/keyboard_handshake_serial_link_top_assert.svh =====
// Assertion macros shared by the link modules.
`ifndef KEYBOARD_HANDSHAKE_SERIAL_LINK_TOP_ASSERT_SVH
`define KEYBOARD_HANDSHAKE_SERIAL_LINK_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KH_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kh assertion failed");

// Next-cycle implication, checked outside reset.
`define KH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kh assertion failed");

`endif

// ===== src/kh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kh_pkg;

  typedef logic [8:0] word_t;

  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_KEY   = 2'd2,
    OP_MOUSE = 2'd3
  } op_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_TX_FIRST = 10'b00_0000_0010,
    PH_TX_BITS  = 10'b00_0000_0100,
    PH_TX_RE_H  = 10'b00_0000_1000,
    PH_TX_RE_L  = 10'b00_0001_0000,
    PH_TX_END   = 10'b00_0010_0000,
    PH_RX_BITS  = 10'b00_0100_0000,
    PH_RX_RE_H  = 10'b00_1000_0000,
    PH_RX_RE_L  = 10'b01_0000_0000,
    PH_RX_END   = 10'b10_0000_0000
  } phase_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_TIMEOUT = 2'd0;
  localparam cfg_idx_t CFG_STEP_TIMEOUT  = 2'd1;

  localparam logic [7:0] START_TIMEOUT_RST = 8'd30;
  localparam logic [7:0] STEP_TIMEOUT_RST  = 8'd6;

  localparam logic [4:0] TX_LAST_STEP = 5'd18;
  localparam logic [4:0] RX_LAST_STEP = 5'd11;

  localparam logic [4:0] CMD_MOUSE = 5'd1;
  localparam logic [2:0] MOUSE_TAG = 3'b101;

  localparam logic signed [11:0] CLAMP_HI = 12'sd126;
  localparam logic signed [11:0] CLAMP_LO = -12'sd128;

  typedef struct packed {
    logic  push;
    word_t data;
    logic  pop;
  } q_ctl_t;

  typedef struct packed {
    logic  empty;
    word_t head;
  } q_stat_t;

  typedef struct packed {
    logic       data_key_line;
    logic       send_request_line;
    logic       irq_line;
    logic       cmd_valid;
    logic [4:0] cmd_code;
  } result_t;

endpackage
`default_nettype wire

// ===== src/kh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface kh_in_if;
  import kh_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [1:0]        port_lines;
  word_t             key_word;
  logic signed [11:0] mouse_dx;
  logic signed [11:0] mouse_dy;
  logic [1:0]        mouse_buttons;

  modport source (output valid, op, port_lines, key_word, mouse_dx, mouse_dy, mouse_buttons,
                  input ready);
  modport sink (input valid, op, port_lines, key_word, mouse_dx, mouse_dy, mouse_buttons,
                output ready);
endinterface
`default_nettype wire

// ===== src/kh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface kh_out_if;
  logic       valid;
  logic       ready;
  logic       data_key_line;
  logic       send_request_line;
  logic       irq_line;
  logic       cmd_valid;
  logic [4:0] cmd_code;

  modport source (output valid, data_key_line, send_request_line, irq_line, cmd_valid,
                  cmd_code, input ready);
  modport sink (input valid, data_key_line, send_request_line, irq_line, cmd_valid,
                cmd_code, output ready);
endinterface
`default_nettype wire

// ===== src/kh_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface kh_cfg_if;
  import kh_pkg::*;
  logic       valid;
  logic       ready;
  cfg_idx_t   index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/kh_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_handshake_serial_link_top_assert.svh"
module kh_queue #(
  parameter int DEPTH = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  input  kh_pkg::q_ctl_t   ctl_i,
  output kh_pkg::q_stat_t  stat_o
);
  import kh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

  word_t          mem [DEPTH];
  word_t          rd_data_r;
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           full;
  logic           empty;
  logic           push_do;
  logic           pop_do;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign push_do = ctl_i.push && !full;
  assign pop_do  = ctl_i.pop && !empty;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop_do) begin
      head_nxt = (head_r == LAST_C) ? '0 : head_r + 1'b1;
    end
    if (push_do) begin
      tail_nxt = (tail_r == LAST_C) ? '0 : tail_r + 1'b1;
    end
    if (push_do && !pop_do) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_do && !push_do) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // The read port always fetches the next head entry, so the head word is ready at a pop.
  always_ff @(posedge clk) begin
    if (push_do) begin
      mem[tail_r] <= ctl_i.data;
    end
    if (push_do && (tail_r == head_nxt)) begin
      rd_data_r <= ctl_i.data;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  assign stat_o.empty = empty;
  assign stat_o.head  = rd_data_r;

  `KH_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `KH_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, ctl_i.pop, !empty)
  `KH_ASSERT_NEXT(a_full_drop, clk, rst_n, ctl_i.push && full && !ctl_i.pop, count_r == DEPTH_C)

endmodule
`default_nettype wire

// ===== src/kh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_handshake_serial_link_top_assert.svh"
module kh_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                step_i,
  input  wire [1:0]          op_i,
  input  wire [1:0]          lines_i,
  input  kh_pkg::word_t      key_word_i,
  input  wire signed [11:0]  mouse_dx_i,
  input  wire signed [11:0]  mouse_dy_i,
  input  wire [1:0]          mouse_buttons_i,
  input  wire [7:0]          start_to_i,
  input  wire [7:0]          step_to_i,
  input  kh_pkg::q_stat_t    kq_stat_i,
  input  kh_pkg::q_stat_t    rq_stat_i,
  output kh_pkg::q_ctl_t     kq_ctl_o,
  output kh_pkg::q_ctl_t     rq_ctl_o,
  output logic               busy_o,
  output kh_pkg::result_t    res_o
);
  import kh_pkg::*;

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic signed [11:0] c;
    c = v;
    if (v > CLAMP_HI) begin
      c = CLAMP_HI;
    end else if (v < CLAMP_LO) begin
      c = CLAMP_LO;
    end
    return c[7:0];
  endfunction

  phase_t             phase_r, phase_nxt;
  logic [4:0]         sub_r, sub_nxt;
  logic [7:0]         ticks_r, ticks_nxt;
  logic [9:0]         sout_r, sout_nxt;
  logic [5:0]         sin_r, sin_nxt;
  logic               din_r, din_nxt;
  logic               stin_r, stin_nxt;
  logic               dk_r, dk_nxt;
  logic               srk_r, srk_nxt;
  logic signed [11:0] mx_r, mx_nxt;
  logic signed [11:0] my_r, my_nxt;
  logic [1:0]         mbtn_r, mbtn_nxt;
  word_t              stage_r [2];
  word_t              stage_nxt [2];
  logic [1:0]         stage_cnt_r, stage_cnt_nxt;

  logic               hs;
  logic               dc;
  logic               stc;
  word_t              tx_word;
  word_t              tx_inv;
  logic [4:0]         cmd;
  logic               cvalid;
  logic [7:0]         mx8;
  logic [7:0]         my8;
  word_t              mw0, mw1, mw2;

  assign mx8 = clamp8(mx_r);
  assign my8 = clamp8(my_r);
  assign mw0 = {MOUSE_TAG, mx8[5:0]};
  assign mw1 = {MOUSE_TAG, my8[5:0]};
  assign mw2 = {MOUSE_TAG, my8[7:6], mx8[7:6], mbtn_r};

  assign tx_word = rq_stat_i.empty ? kq_stat_i.head : rq_stat_i.head;
  assign tx_inv  = ~tx_word;
  assign cmd     = ~sin_r[5:1];

  always_comb begin
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    ticks_nxt     = ticks_r;
    sout_nxt      = sout_r;
    sin_nxt       = sin_r;
    din_nxt       = din_r;
    stin_nxt      = stin_r;
    dk_nxt        = dk_r;
    srk_nxt       = srk_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mbtn_nxt      = mbtn_r;
    stage_nxt[0]  = stage_r[0];
    stage_nxt[1]  = stage_r[1];
    stage_cnt_nxt = stage_cnt_r;
    kq_ctl_o      = '0;
    rq_ctl_o      = '0;
    cvalid        = 1'b0;
    hs            = 1'b0;
    dc            = din_r;
    stc           = stin_r;

    if (stage_cnt_r != 2'd0) begin
      rq_ctl_o.push = 1'b1;
      rq_ctl_o.data = stage_r[0];
      stage_nxt[0]  = stage_r[1];
      stage_cnt_nxt = stage_cnt_r - 1'b1;
    end

    if (step_i) begin
      case (op_t'(op_i))
        OP_LINE: begin
          din_nxt  = !lines_i[0];
          stin_nxt = !lines_i[1];
          hs       = 1'b1;
        end
        OP_TICK: begin
          if (ticks_r != 8'd0) begin
            ticks_nxt = ticks_r - 1'b1;
          end
          hs = 1'b1;
        end
        OP_KEY: begin
          kq_ctl_o.push = 1'b1;
          kq_ctl_o.data = key_word_i;
        end
        default: begin
          mx_nxt   = mouse_dx_i;
          my_nxt   = mouse_dy_i;
          mbtn_nxt = mouse_buttons_i;
        end
      endcase

      dc  = din_nxt;
      stc = stin_nxt;

      if (hs) begin
        case (phase_r)
          PH_IDLE: begin
            if (dc && (!kq_stat_i.empty || !rq_stat_i.empty)) begin
              rq_ctl_o.pop = !rq_stat_i.empty;
              kq_ctl_o.pop = rq_stat_i.empty;
              sout_nxt     = {tx_inv, ^tx_inv};
              dk_nxt       = 1'b0;
              srk_nxt      = 1'b0;
              phase_nxt    = PH_TX_FIRST;
              ticks_nxt    = start_to_i;
            end else if (!dc && !stc) begin
              sin_nxt   = '0;
              dk_nxt    = 1'b0;
              sub_nxt   = '0;
              phase_nxt = PH_RX_BITS;
              ticks_nxt = start_to_i;
            end
          end
          PH_TX_FIRST: begin
            if (!stc) begin
              dk_nxt    = sout_r[9];
              srk_nxt   = 1'b1;
              sub_nxt   = 5'd1;
              phase_nxt = PH_TX_BITS;
              ticks_nxt = step_to_i;
            end
          end
          PH_TX_BITS: begin
            if (sub_r[0] ? stc : !stc) begin
              if (sub_r[0]) begin
                dk_nxt   = sout_r[8];
                sout_nxt = {sout_r[8:0], 1'b0};
              end
              ticks_nxt = step_to_i;
              if (sub_r == TX_LAST_STEP) begin
                phase_nxt = PH_TX_RE_H;
              end else begin
                sub_nxt = sub_r + 1'b1;
              end
            end
          end
          PH_TX_RE_H: begin
            if (stc) begin
              dk_nxt    = 1'b0;
              phase_nxt = PH_TX_RE_L;
              ticks_nxt = step_to_i;
            end
          end
          PH_TX_RE_L: begin
            if (!stc) begin
              phase_nxt = PH_TX_END;
              ticks_nxt = step_to_i;
            end
          end
          PH_TX_END: begin
            if (stc) begin
              dk_nxt    = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_RX_BITS: begin
            if (sub_r[0] ? !stc : stc) begin
              if (sub_r[0]) begin
                sin_nxt = {sin_r[4:0], dc};
              end
              ticks_nxt = step_to_i;
              if (sub_r == RX_LAST_STEP) begin
                phase_nxt = PH_RX_RE_H;
              end else begin
                sub_nxt = sub_r + 1'b1;
              end
            end
          end
          PH_RX_RE_H: begin
            if (stc) begin
              dk_nxt    = 1'b1;
              phase_nxt = PH_RX_RE_L;
              ticks_nxt = step_to_i;
            end
          end
          PH_RX_RE_L: begin
            if (!stc) begin
              phase_nxt = PH_RX_END;
              ticks_nxt = step_to_i;
            end
          end
          PH_RX_END: begin
            if (stc) begin
              cvalid    = 1'b1;
              phase_nxt = PH_IDLE;
              if (cmd == CMD_MOUSE) begin
                rq_ctl_o.push = 1'b1;
                rq_ctl_o.data = mw0;
                stage_nxt[0]  = mw1;
                stage_nxt[1]  = mw2;
                stage_cnt_nxt = 2'd2;
              end
            end
          end
          default: begin
            dk_nxt    = 1'b1;
            srk_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        endcase

        if ((phase_nxt != PH_IDLE) && (ticks_nxt == 8'd0)) begin
          dk_nxt    = 1'b1;
          srk_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sub_r       <= '0;
      ticks_r     <= '0;
      sout_r      <= '0;
      sin_r       <= '0;
      din_r       <= 1'b1;
      stin_r      <= 1'b1;
      dk_r        <= 1'b1;
      srk_r       <= 1'b1;
      mx_r        <= '0;
      my_r        <= '0;
      mbtn_r      <= '0;
      stage_cnt_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      ticks_r     <= ticks_nxt;
      sout_r      <= sout_nxt;
      sin_r       <= sin_nxt;
      din_r       <= din_nxt;
      stin_r      <= stin_nxt;
      dk_r        <= dk_nxt;
      srk_r       <= srk_nxt;
      mx_r        <= mx_nxt;
      my_r        <= my_nxt;
      mbtn_r      <= mbtn_nxt;
      stage_cnt_r <= stage_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r[0] <= stage_nxt[0];
    stage_r[1] <= stage_nxt[1];
  end

  assign busy_o                  = (stage_cnt_r != 2'd0);
  assign res_o.data_key_line     = dk_nxt;
  assign res_o.send_request_line = srk_nxt;
  assign res_o.irq_line          = !srk_nxt;
  assign res_o.cmd_valid         = cvalid;
  assign res_o.cmd_code          = cvalid ? cmd : 5'd0;

  `KH_ASSERT_IMPL(a_stage_idle, clk, rst_n, stage_cnt_r != 2'd0, phase_r == PH_IDLE)
  `KH_ASSERT_IMPL(a_srk_low, clk, rst_n, !srk_r, phase_r == PH_TX_FIRST)
  `KH_ASSERT_IMPL(a_tx_sub, clk, rst_n, phase_r == PH_TX_BITS,
                  (sub_r >= 5'd1) && (sub_r <= TX_LAST_STEP))

endmodule
`default_nettype wire

// ===== src/keyboard_handshake_serial_link_top.sv =====
// A result enters the output register in the cycle after its input transaction is taken.
// Throughput: one transaction per cycle while out_chan is ready, limited by the single
// response-memory write port: host command 1 writes three words; input stalls meanwhile.
// Reset: synchronous, active low; both queues start empty without a clearing pass, and the
// timeout registers return to 30 and 6 ticks.
`timescale 1ns / 1ps
`default_nettype none
module keyboard_handshake_serial_link_top #(
  parameter int KEY_DEPTH  = 64,
  parameter int RESP_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  kh_in_if.sink       in_chan,
  kh_out_if.source    out_chan,
  kh_cfg_if.sink      cfg_chan
);
  import kh_pkg::*;

  logic [7:0] start_to_val_r;
  logic [7:0] step_to_val_r;
  logic       out_valid_r;
  result_t    res_r;
  result_t    res;
  q_ctl_t     kq_ctl;
  q_ctl_t     rq_ctl;
  q_stat_t    kq_stat;
  q_stat_t    rq_stat;
  logic       busy;
  logic       in_ready;
  logic       step;

  assign in_ready      = !busy && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = in_ready;
  assign step          = in_chan.valid && in_ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_to_val_r <= START_TIMEOUT_RST;
      step_to_val_r  <= STEP_TIMEOUT_RST;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_START_TIMEOUT: start_to_val_r <= cfg_chan.data;
          CFG_STEP_TIMEOUT:  step_to_val_r  <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  kh_queue #(.DEPTH(KEY_DEPTH)) u_key_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (kq_ctl),
    .stat_o (kq_stat)
  );

  kh_queue #(.DEPTH(RESP_DEPTH)) u_resp_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (rq_ctl),
    .stat_o (rq_stat)
  );

  kh_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (step),
    .op_i            (in_chan.op),
    .lines_i         (in_chan.port_lines),
    .key_word_i      (in_chan.key_word),
    .mouse_dx_i      (in_chan.mouse_dx),
    .mouse_dy_i      (in_chan.mouse_dy),
    .mouse_buttons_i (in_chan.mouse_buttons),
    .start_to_i      (start_to_val_r),
    .step_to_i       (step_to_val_r),
    .kq_stat_i       (kq_stat),
    .rq_stat_i       (rq_stat),
    .kq_ctl_o        (kq_ctl),
    .rq_ctl_o        (rq_ctl),
    .busy_o          (busy),
    .res_o           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.data_key_line     = res_r.data_key_line;
  assign out_chan.send_request_line = res_r.send_request_line;
  assign out_chan.irq_line          = res_r.irq_line;
  assign out_chan.cmd_valid         = res_r.cmd_valid;
  assign out_chan.cmd_code          = res_r.cmd_code;

endmodule
`default_nettype wire
